[sv/rdw_pkg.sv]
// ----------------------------------------------------------------------------
// rdw_pkg
// Shared widths, register codes, pipeline depths and lane/merge types for the
// regularized delta weight block.
// ----------------------------------------------------------------------------
package rdw_pkg;

	// default number of axes with a lane of their own
	localparam int MAX_DIMS_DEF = 3;

	// port widths
	localparam int COORD_W    = 32;
	localparam int CELL_W     = 32;
	localparam int WEIGHT_W   = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// lane datapath widths
	localparam int X_W     = 32;  // normalized distance, Q.30, quotient bits
	localparam int E_W     = 31;  // distance from the kernel branch center
	localparam int RAD_W   = 62;  // square root argument, Q.60
	localparam int ROOT_W  = 31;  // square root result, Q.30 (one step per bit)
	localparam int N_W     = 36;  // signed numerator, Q.30
	localparam int NUM_W   = 51;  // numerator shifted to the Q.32 factor scale
	localparam int DEN_W   = 35;  // c * width

	// lane depth: abs, support test, divide, center, square, radicand,
	// square root, numerator, divide, clamp
	localparam int LANE_LAT = 2 + X_W + 3 + ROOT_W + 1 + NUM_W + 1;

	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;
	localparam logic [WEIGHT_W-1:0] ONE_Q32    = 48'h0001_0000_0000;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KERNEL   = 3'd0,
		REG_NUM_DIMS = 3'd1,
		REG_WIDTH_X  = 3'd2,
		REG_WIDTH_Y  = 3'd3,
		REG_WIDTH_Z  = 3'd4
	} cfg_reg_t;

	// kernel branch control carried along a lane
	typedef struct packed {
		logic sel;   // 0: three-point, 1: four-point
		logic hi;    // outer branch of the kernel
		logic zero;  // factor known to be zero
	} lane_ctl_t;

	// per-axis factor handed to the merge stage
	typedef struct packed {
		logic [WEIGHT_W-1:0] factor;
		logic                clamp;
		logic                zero;
	} lane_res_t;

	// running product in the merge chain
	typedef struct packed {
		logic [WEIGHT_W-1:0] w;
		logic                sat;
		logic                zero;
	} acc_t;

endpackage

[sv/rdw_if.sv]
// ----------------------------------------------------------------------------
// rdw_point_if / rdw_result_if
// Valid/ready channels carrying a point pair and a weight result.
// ----------------------------------------------------------------------------
interface rdw_point_if;
	import rdw_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] source_x;
	logic signed [COORD_W-1:0] source_y;
	logic signed [COORD_W-1:0] source_z;
	logic signed [COORD_W-1:0] target_x;
	logic signed [COORD_W-1:0] target_y;
	logic signed [COORD_W-1:0] target_z;
	modport source (output valid, source_x, source_y, source_z,
		target_x, target_y, target_z, input ready);
	modport sink (input valid, source_x, source_y, source_z,
		target_x, target_y, target_z, output ready);
endinterface

interface rdw_result_if;
	import rdw_pkg::*;
	logic                valid;
	logic                ready;
	logic [WEIGHT_W-1:0] weight;
	logic                saturated;
	modport source (output valid, weight, saturated, input ready);
	modport sink (input valid, weight, saturated, output ready);
endinterface

[sv/regularized_delta_weight.sv]
// ----------------------------------------------------------------------------
// regularized_delta_weight
// Discrete delta weight between two points: one lane per axis computes the
// kernel factor, the merge stage multiplies the factors into a Q16.32 weight.
// ----------------------------------------------------------------------------
// Pipeline: the depth is set mostly by the two bit-serial dividers
//   (32 and 51 stages) and the 31-stage square root in each lane,
//   followed by the merge stage.
// Throughput: one item per cycle; the pipeline stalls only when the
//   two-entry output buffer is full.
// Reset: arst_n clears the pipeline valids, the output buffer and the
//   registers (three-point kernel, two axes, widths 1.0).
module regularized_delta_weight #(
	parameter int MAX_DIMS = rdw_pkg::MAX_DIMS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [rdw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rdw_pkg::CFG_DATA_W-1:0]  cfg_data,
	rdw_point_if.sink                       points,
	rdw_result_if.source                    result
);
	import rdw_pkg::*;

	localparam int LAT = LANE_LAT + 1 + 2 * MAX_DIMS;

	typedef struct packed {
		logic [WEIGHT_W-1:0] weight;
		logic                saturated;
	} out_t;

	// configuration registers
	logic              kernel_q;
	logic [1:0]        num_dims_q;
	logic [CELL_W-1:0] cell_width_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q        <= 1'b0;
			num_dims_q      <= 2'd2;
			cell_width_q[0] <= 32'h0001_0000;
			cell_width_q[1] <= 32'h0001_0000;
			cell_width_q[2] <= 32'h0001_0000;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_KERNEL:   kernel_q        <= cfg_data[0];
				REG_NUM_DIMS: num_dims_q      <= cfg_data[1:0];
				REG_WIDTH_X:  cell_width_q[0] <= cfg_data;
				REG_WIDTH_Y:  cell_width_q[1] <= cfg_data;
				REG_WIDTH_Z:  cell_width_q[2] <= cfg_data;
				default:      ;
			endcase
		end
	end

	// pipeline advance and valid tracking
	logic           en;
	logic           in_xfer;
	logic [LAT-1:0] vld_q;
	logic [1:0]     cnt_q;

	assign en           = cnt_q != 2'd2;
	assign points.ready = en;
	assign in_xfer      = points.valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-2:0], in_xfer};
	end

	// axis lanes
	logic signed [COORD_W-1:0] src [3];
	logic signed [COORD_W-1:0] tgt [3];
	lane_res_t                 lane_res [MAX_DIMS];

	assign src[0] = points.source_x;
	assign src[1] = points.source_y;
	assign src[2] = points.source_z;
	assign tgt[0] = points.target_x;
	assign tgt[1] = points.target_y;
	assign tgt[2] = points.target_z;

	for (genvar d = 0; d < MAX_DIMS; d++) begin : g_lane
		rdw_lane u_lane (
			.clk        (clk),
			.en         (en),
			.source     (src[d]),
			.target     (tgt[d]),
			.cell_width (cell_width_q[d]),
			.kernel_sel (kernel_q),
			.res        (lane_res[d])
		);
	end

	// product of the lane factors
	out_t mrg;

	rdw_merge #(
		.MAX_DIMS (MAX_DIMS)
	) u_merge (
		.clk       (clk),
		.en        (en),
		.lane_res  (lane_res),
		.num_dims  (num_dims_q),
		.weight    (mrg.weight),
		.saturated (mrg.saturated)
	);

	// two-entry output buffer
	out_t       buf_q [2];
	logic       wr_q;
	logic       rd_q;
	logic       push;
	logic       pop;

	assign push = en && vld_q[LAT-1];
	assign pop  = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_q] <= mrg;
	end

	assign result.valid     = cnt_q != '0;
	assign result.weight    = buf_q[rd_q].weight;
	assign result.saturated = buf_q[rd_q].saturated;

endmodule

[sv/rdw_div.sv]
// ----------------------------------------------------------------------------
// rdw_div
// Pipelined restoring divider, one quotient bit per stage. The quotient is
// assumed to fit in Q_W bits; a sideband word travels alongside.
// ----------------------------------------------------------------------------
module rdw_div #(
	parameter int DVD_W  = 62,
	parameter int DVS_W  = 32,
	parameter int Q_W    = 32,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              en,
	input  logic [DVD_W-1:0]  dividend,
	input  logic [DVS_W-1:0]  divisor,
	input  logic [SIDE_W-1:0] side_in,
	output logic [Q_W-1:0]    quotient,
	output logic [SIDE_W-1:0] side_out
);

	logic [DVS_W-1:0]  rem_s  [Q_W+1];
	logic [Q_W-1:0]    low_s  [Q_W+1];
	logic [Q_W-1:0]    quo_s  [Q_W+1];
	logic [DVS_W-1:0]  dvs_s  [Q_W+1];
	logic [SIDE_W-1:0] side_s [Q_W+1];

	// upper dividend bits preload the remainder
	assign rem_s[0]  = DVS_W'(dividend >> Q_W);
	assign low_s[0]  = dividend[Q_W-1:0];
	assign quo_s[0]  = '0;
	assign dvs_s[0]  = divisor;
	assign side_s[0] = side_in;

	for (genvar i = 0; i < Q_W; i++) begin : g_step
		logic [DVS_W:0] trial;
		logic           ge;

		// shift in the next dividend bit and try a subtract
		assign trial = {rem_s[i], low_s[i][Q_W-1]};
		assign ge    = trial >= {1'b0, dvs_s[i]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? DVS_W'(trial - {1'b0, dvs_s[i]}) : trial[DVS_W-1:0];
				low_s[i+1]  <= low_s[i] << 1;
				quo_s[i+1]  <= {quo_s[i][Q_W-2:0], ge};
				dvs_s[i+1]  <= dvs_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign quotient = quo_s[Q_W];
	assign side_out = side_s[Q_W];

endmodule

[sv/rdw_sqrt.sv]
// ----------------------------------------------------------------------------
// rdw_sqrt
// Pipelined floor integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rdw_sqrt #(
	parameter int IN_W   = 62,
	parameter int STEPS  = 31,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              en,
	input  logic [IN_W-1:0]   radicand,
	input  logic [SIDE_W-1:0] side_in,
	output logic [STEPS-1:0]  root,
	output logic [SIDE_W-1:0] side_out
);

	localparam int RW = IN_W + 1;

	logic [RW-1:0]     v_s    [STEPS+1];
	logic [RW-1:0]     r_s    [STEPS+1];
	logic [SIDE_W-1:0] side_s [STEPS+1];

	assign v_s[0]    = RW'(radicand);
	assign r_s[0]    = '0;
	assign side_s[0] = side_in;

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam int K = STEPS - 1 - i;
		localparam logic [RW-1:0] BIT = RW'(1) << (2 * K);
		logic [RW-1:0] trial;
		logic          ge;

		// digit-by-digit: test the next pair of bits
		assign trial = r_s[i] + BIT;
		assign ge    = v_s[i] >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				v_s[i+1]    <= ge ? v_s[i] - trial : v_s[i];
				r_s[i+1]    <= ge ? (r_s[i] >> 1) + BIT : r_s[i] >> 1;
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign root     = r_s[STEPS][STEPS-1:0];
	assign side_out = side_s[STEPS];

endmodule

[sv/rdw_lane.sv]
// ----------------------------------------------------------------------------
// rdw_lane
// One axis: distance, support test, normalized distance, kernel square root
// and final divide to an unsigned Q.32 factor with clamp and zero flags.
// ----------------------------------------------------------------------------
module rdw_lane (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [rdw_pkg::COORD_W-1:0] source,
	input  logic signed [rdw_pkg::COORD_W-1:0] target,
	input  logic [rdw_pkg::CELL_W-1:0]         cell_width,
	input  logic                               kernel_sel,
	output rdw_pkg::lane_res_t                 res
);
	import rdw_pkg::*;

	localparam logic [X_W-1:0]   CTR_HALF  = 32'h2000_0000;
	localparam logic [X_W-1:0]   CTR_ONE   = 32'h4000_0000;
	localparam logic [X_W-1:0]   CTR_3HALF = 32'h6000_0000;
	localparam logic [RAD_W-1:0] RAD_ONE   = 62'h1000_0000_0000_0000;
	localparam logic [RAD_W-1:0] RAD_TWO   = 62'h2000_0000_0000_0000;
	localparam logic [N_W-1:0]   N_ONE     = 36'h0_4000_0000;
	localparam logic [N_W-1:0]   N_THREE   = 36'h0_C000_0000;
	localparam logic [N_W-1:0]   N_FIVE    = 36'h1_4000_0000;

	// stage 1: absolute distance
	logic signed [COORD_W:0] diff;
	logic [COORD_W-1:0]      a_s1;
	logic [CELL_W-1:0]       w_s1;
	logic                    sel_s1;

	assign diff = (COORD_W+1)'(source) - (COORD_W+1)'(target);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
			w_s1   <= cell_width;
			sel_s1 <= kernel_sel;
		end
	end

	// stage 2: exact support and branch tests on a and w
	logic [COORD_W:0]   a2;
	logic [CELL_W+1:0]  w3;
	logic [COORD_W-1:0] a_s2;
	logic [CELL_W-1:0]  w_s2;
	lane_ctl_t          ctl_s2;

	assign a2 = {a_s1, 1'b0};
	assign w3 = {1'b0, w_s1, 1'b0} + (CELL_W+2)'(w_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2       <= a_s1;
			w_s2       <= w_s1;
			ctl_s2.sel <= sel_s1;
			if (!sel_s1) begin
				ctl_s2.zero <= (w_s1 == '0) || ((CELL_W+2)'(a2) > w3);
				ctl_s2.hi   <= a2 > (COORD_W+1)'(w_s1);
			end else begin
				ctl_s2.zero <= (w_s1 == '0) || ((COORD_W+1)'(a_s1) > {w_s1, 1'b0});
				ctl_s2.hi   <= a_s1 > w_s1;
			end
		end
	end

	// x30 = floor(a * 2^30 / w)
	logic [X_W-1:0]    x30_d;
	lane_ctl_t         ctl_d;
	logic [CELL_W-1:0] w_d;

	rdw_div #(
		.DVD_W  (COORD_W + 30),
		.DVS_W  (CELL_W),
		.Q_W    (X_W),
		.SIDE_W ($bits(lane_ctl_t) + CELL_W)
	) u_div_x (
		.clk      (clk),
		.en       (en),
		.dividend ({a_s2, 30'b0}),
		.divisor  (w_s2),
		.side_in  ({ctl_s2, w_s2}),
		.quotient (x30_d),
		.side_out ({ctl_d, w_d})
	);

	// stage 3: distance from the branch center
	logic [X_W-1:0]    ctr;
	logic [X_W-1:0]    e_s3;
	logic [X_W-1:0]    x30_s3;
	lane_ctl_t         ctl_s3;
	logic [CELL_W-1:0] w_s3;

	always_comb begin
		if (ctl_d.sel)
			ctr = ctl_d.hi ? CTR_3HALF : CTR_HALF;
		else
			ctr = ctl_d.hi ? CTR_ONE : '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s3   <= (x30_d >= ctr) ? x30_d - ctr : ctr - x30_d;
			x30_s3 <= x30_d;
			ctl_s3 <= ctl_d;
			w_s3   <= w_d;
		end
	end

	// stage 4: square
	logic [RAD_W-1:0]  sq_s4;
	logic [X_W-1:0]    x30_s4;
	lane_ctl_t         ctl_s4;
	logic [CELL_W-1:0] w_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s4  <= RAD_W'(e_s3[E_W-1:0]) * RAD_W'(e_s3[E_W-1:0]);
			x30_s4 <= x30_s3;
			ctl_s4 <= ctl_s3;
			w_s4   <= w_s3;
		end
	end

	// stage 5: radicand, 1 - 3e^2 or 2 - 4e^2 in Q.60
	logic [RAD_W-1:0]  rad_s5;
	logic [X_W-1:0]    x30_s5;
	lane_ctl_t         ctl_s5;
	logic [CELL_W-1:0] w_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s5 <= ctl_s4.sel ? RAD_TWO - (sq_s4 << 2) : RAD_ONE - (sq_s4 + (sq_s4 << 1));
			x30_s5 <= x30_s4;
			ctl_s5 <= ctl_s4;
			w_s5   <= w_s4;
		end
	end

	logic [ROOT_W-1:0] root_d;
	logic [X_W-1:0]    x30_r;
	lane_ctl_t         ctl_r;
	logic [CELL_W-1:0] w_r;

	rdw_sqrt #(
		.IN_W   (RAD_W),
		.STEPS  (ROOT_W),
		.SIDE_W ($bits(lane_ctl_t) + CELL_W + X_W)
	) u_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (rad_s5),
		.side_in  ({ctl_s5, w_s5, x30_s5}),
		.root     (root_d),
		.side_out ({ctl_r, w_r, x30_r})
	);

	// stage 6: numerator and divisor c*w
	logic [N_W-1:0]    xx;
	logic [N_W-1:0]    rt;
	logic [N_W-1:0]    n;
	logic [DEN_W-1:0]  w3e;
	logic [NUM_W-1:0]  num_s6;
	logic [DEN_W-1:0]  den_s6;
	logic              zero_s6;

	assign xx  = N_W'(x30_r);
	assign rt  = N_W'(root_d);
	assign w3e = DEN_W'(w_r) + (DEN_W'(w_r) << 1);

	always_comb begin
		case ({ctl_r.sel, ctl_r.hi})
			2'b00:   n = N_ONE + rt;
			2'b01:   n = N_FIVE - (xx + (xx << 1)) - rt;
			2'b10:   n = N_THREE - (xx << 1) + rt;
			2'b11:   n = N_FIVE - (xx << 1) - rt;
			default: n = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s6  <= {n[NUM_W-19:0], 18'b0};
			if (ctl_r.sel)
				den_s6 <= DEN_W'(w_r) << 3;
			else
				den_s6 <= ctl_r.hi ? w3e << 1 : w3e;
			zero_s6 <= ctl_r.zero || n[N_W-1] || (n == '0);
		end
	end

	// factor = floor(N * 2^18 / (c * w))
	logic [NUM_W-1:0] q_d;
	logic             zero_d;

	rdw_div #(
		.DVD_W  (NUM_W),
		.DVS_W  (DEN_W),
		.Q_W    (NUM_W),
		.SIDE_W (1)
	) u_div_f (
		.clk      (clk),
		.en       (en),
		.dividend (num_s6),
		.divisor  (den_s6),
		.side_in  (zero_s6),
		.quotient (q_d),
		.side_out (zero_d)
	);

	// stage 7: clamp to the weight range
	logic q_big;

	assign q_big = q_d[NUM_W-1:WEIGHT_W] != '0;

	always_ff @(posedge clk) begin
		if (en) begin
			res.zero  <= zero_d || (q_d == '0);
			res.clamp <= !zero_d && q_big;
			if (zero_d)
				res.factor <= '0;
			else
				res.factor <= q_big ? WEIGHT_MAX : q_d[WEIGHT_W-1:0];
		end
	end

endmodule

[sv/rdw_merge.sv]
// ----------------------------------------------------------------------------
// rdw_merge
// Multiplies the active lane factors into one Q16.32 weight, two stages per
// axis (partial products, then sum and clamp), with sticky saturation.
// ----------------------------------------------------------------------------
module rdw_merge #(
	parameter int MAX_DIMS = rdw_pkg::MAX_DIMS_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  rdw_pkg::lane_res_t            lane_res [MAX_DIMS],
	input  logic [1:0]                    num_dims,
	output logic [rdw_pkg::WEIGHT_W-1:0]  weight,
	output logic                          saturated
);
	import rdw_pkg::*;

	logic [1:0]          nd_eff;
	logic [MAX_DIMS-1:0] act_c;
	logic [MAX_DIMS-1:0] clamp_c;
	logic [MAX_DIMS-1:0] zero_c;

	acc_t                acc_s [MAX_DIMS+1];
	logic [MAX_DIMS-1:0] act_s [MAX_DIMS+1];
	logic [WEIGHT_W-1:0] fac_s [MAX_DIMS+1][MAX_DIMS];

	// active axes are the first num_dims, capped at the lane count
	assign nd_eff = (num_dims > 2'(MAX_DIMS)) ? 2'(MAX_DIMS) : num_dims;

	for (genvar d = 0; d < MAX_DIMS; d++) begin : g_flags
		assign act_c[d]   = 2'(d) < nd_eff;
		assign clamp_c[d] = lane_res[d].clamp;
		assign zero_c[d]  = lane_res[d].zero;
	end

	// stage 0: gather flags, product starts at 1.0
	always_ff @(posedge clk) begin
		if (en) begin
			acc_s[0].w    <= ONE_Q32;
			acc_s[0].sat  <= |(act_c & clamp_c);
			acc_s[0].zero <= |(act_c & zero_c);
			act_s[0]      <= act_c;
			for (int d = 0; d < MAX_DIMS; d++)
				fac_s[0][d] <= lane_res[d].factor;
		end
	end

	for (genvar d = 0; d < MAX_DIMS; d++) begin : g_mul
		logic [31:0]         hh_a;
		logic [47:0]         ahbl_a;
		logic [47:0]         albh_a;
		logic [31:0]         albl_a;
		acc_t                acc_a;
		logic [MAX_DIMS-1:0] act_a;
		logic [WEIGHT_W-1:0] fac_a [MAX_DIMS];
		logic [63:0]         albl;
		logic [63:0]         sum;

		assign albl = 64'(acc_s[d].w[31:0]) * 64'(fac_s[d][d][31:0]);

		// stage A: partial products of w * f
		always_ff @(posedge clk) begin
			if (en) begin
				hh_a   <= 32'(acc_s[d].w[47:32]) * 32'(fac_s[d][d][47:32]);
				ahbl_a <= 48'(acc_s[d].w[47:32]) * 48'(fac_s[d][d][31:0]);
				albh_a <= 48'(acc_s[d].w[31:0]) * 48'(fac_s[d][d][47:32]);
				albl_a <= albl[63:32];
				acc_a  <= acc_s[d];
				act_a  <= act_s[d];
				fac_a  <= fac_s[d];
			end
		end

		assign sum = (64'(hh_a) << 32) + 64'(ahbl_a) + 64'(albh_a) + 64'(albl_a);

		// stage B: sum, floor by 2^32, clamp
		always_ff @(posedge clk) begin
			if (en) begin
				act_s[d+1]      <= act_a;
				fac_s[d+1]      <= fac_a;
				acc_s[d+1].zero <= acc_a.zero;
				if (!act_a[d]) begin
					acc_s[d+1].w   <= acc_a.w;
					acc_s[d+1].sat <= acc_a.sat;
				end else if ((hh_a[31:16] != '0) || (sum > 64'(WEIGHT_MAX))) begin
					acc_s[d+1].w   <= WEIGHT_MAX;
					acc_s[d+1].sat <= 1'b1;
				end else begin
					acc_s[d+1].w   <= sum[WEIGHT_W-1:0];
					acc_s[d+1].sat <= acc_a.sat;
				end
			end
		end
	end

	// any zero factor on an active axis forces a clean zero
	assign weight    = acc_s[MAX_DIMS].zero ? '0 : acc_s[MAX_DIMS].w;
	assign saturated = !acc_s[MAX_DIMS].zero && acc_s[MAX_DIMS].sat;

endmodule

[sv/rdw_checker.sv]
// ----------------------------------------------------------------------------
// rdw_checker
// Port-level checks on the weight block, bound to the top level.
// ----------------------------------------------------------------------------
module rdw_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [rdw_pkg::WEIGHT_W-1:0]  weight,
	input logic                          saturated
);
	import rdw_pkg::*;

	// handshake controls are always driven while an input is offered
	a_ctrl_known: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> !$isunknown({in_ready, out_valid}))
		else $error("handshake control unknown while input offered");

	// input only backs up when results are waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no pending result");

	// nothing is offered during reset
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result offered in reset");

	// a waiting result holds until transferred
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(weight) && $stable(saturated))
		else $error("result changed while stalled");

endmodule

bind regularized_delta_weight rdw_checker u_rdw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (points.valid),
	.in_ready  (points.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.weight    (result.weight),
	.saturated (result.saturated)
);
